@@ rtl/core/teq_pkg.sv @@
// Shared types and constants for the timed event queue.
// Request and result transfer structs, table entry layout, command codes.
// No dependencies.
`default_nettype none

package teq_pkg;

    localparam int HANDLE_W   = 16;
    localparam int AUX_W      = 32;
    localparam int TIME_W     = 48;

    localparam logic [1:0] CMD_ADD_IMM   = 2'd0;
    localparam logic [1:0] CMD_ADD_TIMED = 2'd1;
    localparam logic [1:0] CMD_POLL      = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [HANDLE_W-1:0] event_handle;
        logic [AUX_W-1:0]    event_aux;
        logic [TIME_W-1:0]   deadline_us;
        logic [TIME_W-1:0]   now_us;
    } teq_req_t;

    typedef struct packed {
        logic                event_valid;
        logic [HANDLE_W-1:0] fired_handle;
        logic [AUX_W-1:0]    fired_aux;
        logic                from_timed;
        logic                status;
        logic                last;
    } teq_rsp_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [AUX_W-1:0]    aux;
    } imm_entry_t;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
        logic [AUX_W-1:0]    aux;
    } timed_entry_t;

endpackage

`default_nettype wire

@@ rtl/core/teq_timed_store.sv @@
// Circular storage for the deadline-sorted timed table.
// Maps a logical position onto a slot past the head; one write, one registered read.
// Depends on teq_pkg.
`default_nettype none

module teq_timed_store
    import teq_pkg::*;
#(
    parameter int TIMED_DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic [((TIMED_DEPTH > 1) ? $clog2(TIMED_DEPTH) : 1)-1:0] head,
    input  wire logic [$clog2(TIMED_DEPTH + 1)-1:0]     lidx,
    input  wire logic                                    wr_en,
    input  wire timed_entry_t                            wr_entry,
    output timed_entry_t                                 rd_entry,
    output logic [((TIMED_DEPTH > 1) ? $clog2(TIMED_DEPTH) : 1)-1:0] slot
);

    localparam int TCW = $clog2(TIMED_DEPTH + 1);
    localparam int TAW = (TIMED_DEPTH > 1) ? $clog2(TIMED_DEPTH) : 1;
    localparam int TSW = TCW + 1;

    timed_entry_t     mem [TIMED_DEPTH];
    timed_entry_t     rd_reg;
    logic [TSW-1:0]   sum;
    logic [TSW-1:0]   wrapped;

    always_comb
    begin
        sum     = {{(TSW-TAW){1'b0}}, head} + {1'b0, lidx};
        wrapped = (sum >= TSW'(TIMED_DEPTH)) ? (sum - TSW'(TIMED_DEPTH)) : sum;
        slot    = wrapped[TAW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot] <= wr_entry;
        end
        rd_reg <= mem[slot];
    end

    assign rd_entry = rd_reg;

endmodule

`default_nettype wire

@@ rtl/core/timed_event_queue.sv @@
// Top level of the timed event queue: immediate FIFO, sequencer, result register.
// Depends on teq_pkg and teq_timed_store.
//
// One request is taken at a time; req_stall is high until its last result is
// loaded into the output register. An immediate add, an add to a full store and
// an unused command go straight to the final result. A timed add walks back from
// the tail and moves up each entry whose deadline is later than the new one, then
// writes the new entry behind the first entry that stays ahead of it; every step
// of the sorted insertion goes through the single read port of the timed table
// and one shared deadline compare. A poll returns each queued immediate event,
// then each due timed event; results wait while rsp_stall holds the output
// register. The timed table is a ring, so removing due events is a single head
// update, regardless of how many fired.
`default_nettype none

module timed_event_queue
    import teq_pkg::*;
#(
    parameter int IMM_DEPTH   = 16,
    parameter int TIMED_DEPTH = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire teq_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output teq_rsp_t      rsp
);

    localparam int ICW = $clog2(IMM_DEPTH + 1);
    localparam int IAW = (IMM_DEPTH > 1) ? $clog2(IMM_DEPTH) : 1;
    localparam int TCW = $clog2(TIMED_DEPTH + 1);
    localparam int TAW = (TIMED_DEPTH > 1) ? $clog2(TIMED_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_IMM_RD,
        S_IMM_GET,
        S_TM_RD,
        S_TM_CMP,
        S_DROP,
        S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [ICW-1:0]   imm_count_reg, imm_count_next;
    logic [ICW-1:0]   jidx_reg, jidx_next;
    logic [TCW-1:0]   sched_count_reg, sched_count_next;
    logic [TCW-1:0]   tidx_reg, tidx_next;
    logic [TAW-1:0]   head_reg, head_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             rsp_valid_reg, rsp_valid_next;

    teq_rsp_t         pend_reg, pend_next;
    teq_rsp_t         rsp_reg, rsp_next;
    timed_entry_t     ent_reg, ent_next;
    logic [TIME_W-1:0] key_reg, key_next;

    imm_entry_t       imm_mem [IMM_DEPTH];
    imm_entry_t       imm_rd_reg;
    logic             imm_wr_en;

    logic [TCW-1:0]   lidx;
    logic             tm_wr_en;
    timed_entry_t     tm_wr_entry;
    timed_entry_t     tm_rd_entry;
    logic [TAW-1:0]   tm_slot;

    logic             can_push;
    logic             push_en;
    teq_rsp_t         push_data;
    logic             due;
    teq_rsp_t         add_ok;
    teq_rsp_t         add_full;

    teq_timed_store #(
        .TIMED_DEPTH (TIMED_DEPTH)
    ) u_store (
        .clk      (clk),
        .head     (head_reg),
        .lidx     (lidx),
        .wr_en    (tm_wr_en),
        .wr_entry (tm_wr_entry),
        .rd_entry (tm_rd_entry),
        .slot     (tm_slot)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        can_push = !rsp_valid_reg || !rsp_stall;
        due      = (tm_rd_entry.deadline <= key_reg);
        add_ok   = '0;
        add_full = '0;
        add_full.status = STATUS_FULL;
        add_ok.status   = STATUS_OK;

        state_next       = state_reg;
        imm_count_next   = imm_count_reg;
        jidx_next        = jidx_reg;
        sched_count_next = sched_count_reg;
        tidx_next        = tidx_reg;
        head_next        = head_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        ent_next         = ent_reg;
        key_next         = key_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;

        imm_wr_en   = 1'b0;
        tm_wr_en    = 1'b0;
        tm_wr_entry = ent_reg;
        lidx        = tidx_reg;
        push_en     = 1'b0;
        push_data   = pend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ent_next.deadline = req.deadline_us;
                    ent_next.handle   = req.event_handle;
                    ent_next.aux      = req.event_aux;
                    key_next = (req.cmd == CMD_ADD_TIMED) ? req.deadline_us : req.now_us;
                    case (req.cmd)
                        CMD_ADD_IMM:
                        begin
                            pend_valid_next = 1'b1;
                            if (imm_count_reg == ICW'(IMM_DEPTH))
                            begin
                                pend_next = add_full;
                            end
                            else
                            begin
                                imm_wr_en      = 1'b1;
                                imm_count_next = imm_count_reg + ICW'(1);
                                pend_next      = add_ok;
                            end
                            state_next = S_FIN;
                        end
                        CMD_ADD_TIMED:
                        begin
                            if (sched_count_reg == TCW'(TIMED_DEPTH))
                            begin
                                pend_valid_next = 1'b1;
                                pend_next       = add_full;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                tidx_next  = sched_count_reg;
                                state_next = S_INS_CHK;
                            end
                        end
                        CMD_POLL:
                        begin
                            jidx_next  = '0;
                            state_next = S_IMM_RD;
                        end
                        default:
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = S_FIN;
                        end
                    endcase
                end
            end
            S_INS_CHK:
            begin
                if (tidx_reg == '0)
                begin
                    lidx             = '0;
                    tm_wr_en         = 1'b1;
                    sched_count_next = sched_count_reg + TCW'(1);
                    pend_valid_next  = 1'b1;
                    pend_next        = add_ok;
                    state_next       = S_FIN;
                end
                else
                begin
                    lidx       = tidx_reg - TCW'(1);
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                tm_wr_en = 1'b1;
                if (due)
                begin
                    sched_count_next = sched_count_reg + TCW'(1);
                    pend_valid_next  = 1'b1;
                    pend_next        = add_ok;
                    state_next       = S_FIN;
                end
                else
                begin
                    tm_wr_entry = tm_rd_entry;
                    tidx_next   = tidx_reg - TCW'(1);
                    state_next  = S_INS_CHK;
                end
            end
            S_IMM_RD:
            begin
                if (jidx_reg == imm_count_reg)
                begin
                    imm_count_next = '0;
                    tidx_next      = '0;
                    state_next     = S_TM_RD;
                end
                else
                begin
                    state_next = S_IMM_GET;
                end
            end
            S_IMM_GET:
            begin
                if (!pend_valid_reg || can_push)
                begin
                    push_en                = pend_valid_reg;
                    pend_valid_next        = 1'b1;
                    pend_next              = '0;
                    pend_next.event_valid  = 1'b1;
                    pend_next.fired_handle = imm_rd_reg.handle;
                    pend_next.fired_aux    = imm_rd_reg.aux;
                    jidx_next              = jidx_reg + ICW'(1);
                    state_next             = S_IMM_RD;
                end
            end
            S_TM_RD:
            begin
                state_next = (tidx_reg == sched_count_reg) ? S_DROP : S_TM_CMP;
            end
            S_TM_CMP:
            begin
                if (!due)
                begin
                    state_next = S_DROP;
                end
                else if (!pend_valid_reg || can_push)
                begin
                    push_en                = pend_valid_reg;
                    pend_valid_next        = 1'b1;
                    pend_next              = '0;
                    pend_next.event_valid  = 1'b1;
                    pend_next.fired_handle = tm_rd_entry.handle;
                    pend_next.fired_aux    = tm_rd_entry.aux;
                    pend_next.from_timed   = 1'b1;
                    tidx_next              = tidx_reg + TCW'(1);
                    state_next             = S_TM_RD;
                end
            end
            S_DROP:
            begin
                head_next        = tm_slot;
                sched_count_next = sched_count_reg - tidx_reg;
                state_next       = S_FIN;
            end
            S_FIN:
            begin
                if (can_push)
                begin
                    push_en        = 1'b1;
                    push_data      = pend_valid_reg ? pend_reg : '0;
                    push_data.last = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            imm_count_reg   <= '0;
            jidx_reg        <= '0;
            sched_count_reg <= '0;
            tidx_reg        <= '0;
            head_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            imm_count_reg   <= imm_count_next;
            jidx_reg        <= jidx_next;
            sched_count_reg <= sched_count_next;
            tidx_reg        <= tidx_next;
            head_reg        <= head_next;
            pend_valid_reg  <= pend_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
        ent_reg  <= ent_next;
        key_reg  <= key_next;
    end

    always_ff @(posedge clk)
    begin
        if (imm_wr_en)
        begin
            imm_mem[imm_count_reg[IAW-1:0]] <= '{handle: req.event_handle, aux: req.event_aux};
        end
        imm_rd_reg <= imm_mem[jidx_reg[IAW-1:0]];
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_timed_event_queue.sv @@
// Self-checking testbench for timed_event_queue: a directed table, then random traffic.
// It predicts fired events with its own immediate FIFO and a deadline-sorted timed table.
// Depends on teq_pkg and the timed_event_queue RTL.
`timescale 1ns / 1ps

module tb_timed_event_queue;
    import teq_pkg::*;

    localparam int IMM_DEPTH    = 16;
    localparam int TIMED_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 380;
    localparam int WATCHDOG     = 3000;
    localparam int DRAIN_CYCLES = 200;

    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam logic [47:0] TIME_MAX   = 48'hFFFF_FFFF_FFFF;

    localparam teq_rsp_t RSP_ACK = '{event_valid: 1'b0, fired_handle: '0, fired_aux: '0,
                                     from_timed: 1'b0, status: STATUS_OK, last: 1'b1};
    localparam teq_rsp_t RSP_FULL = '{event_valid: 1'b0, fired_handle: '0, fired_aux: '0,
                                      from_timed: 1'b0, status: STATUS_FULL, last: 1'b1};
    localparam teq_rsp_t RSP_EMPTY = RSP_ACK;

    typedef struct {
        teq_req_t req;
        bit       typed;
        teq_rsp_t want;
    } dir_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    teq_req_t req;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    teq_rsp_t rsp;

    bit       row_typed;
    teq_rsp_t row_want;

    imm_entry_t   imm_q[$];
    timed_entry_t timed_q[$];
    teq_rsp_t     awaited_rsp[$];
    dir_row_t     rows[$];

    int mismatches = 0;
    int idle_cycles = 0;
    int stim_count;
    int send_calm;
    int rsp_calm = 0;
    int stall_left = 0;

    timed_event_queue #(
        .IMM_DEPTH  (IMM_DEPTH),
        .TIMED_DEPTH(TIMED_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm = $urandom_range(15, 50);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TIME_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[TIME_W-1:0];
    endfunction

    function automatic teq_req_t mk_req(logic [1:0] cmd, logic [HANDLE_W-1:0] handle,
                                        logic [AUX_W-1:0] aux, logic [TIME_W-1:0] deadline,
                                        logic [TIME_W-1:0] now);
        teq_req_t r;
        r.cmd          = cmd;
        r.event_handle = handle;
        r.event_aux    = aux;
        r.deadline_us  = deadline;
        r.now_us       = now;
        return r;
    endfunction

    function automatic teq_rsp_t fired(imm_entry_t e, logic timed);
        teq_rsp_t f;
        f = RSP_ACK;
        f.event_valid  = 1'b1;
        f.fired_handle = e.handle;
        f.fired_aux    = e.aux;
        f.from_timed   = timed;
        f.last         = 1'b0;
        return f;
    endfunction

    function automatic void predict_dispatch(teq_req_t r, bit typed, teq_rsp_t want);
        teq_rsp_t     outs[$];
        timed_entry_t t;
        int           pos;
        case (r.cmd)
            CMD_ADD_IMM:
            begin
                if (imm_q.size() < IMM_DEPTH)
                begin
                    imm_q.insert(imm_q.size(), '{handle: r.event_handle, aux: r.event_aux});
                    outs.insert(outs.size(), RSP_ACK);
                end
                else
                    outs.insert(outs.size(), RSP_FULL);
            end
            CMD_ADD_TIMED:
            begin
                if (timed_q.size() < TIMED_DEPTH)
                begin
                    pos = 0;
                    while (pos < timed_q.size() && timed_q[pos].deadline <= r.deadline_us)
                        pos++;
                    timed_q.insert(pos, '{deadline: r.deadline_us, handle: r.event_handle,
                                          aux: r.event_aux});
                    outs.insert(outs.size(), RSP_ACK);
                end
                else
                    outs.insert(outs.size(), RSP_FULL);
            end
            CMD_POLL:
            begin
                while (imm_q.size() > 0)
                begin
                    outs.insert(outs.size(), fired(imm_q[0], 1'b0));
                    imm_q.delete(0);
                end
                while (timed_q.size() > 0 && timed_q[0].deadline <= r.now_us)
                begin
                    t = timed_q[0];
                    timed_q.delete(0);
                    outs.insert(outs.size(), fired('{handle: t.handle, aux: t.aux}, 1'b1));
                end
                if (outs.size() == 0)
                    outs.insert(outs.size(), RSP_EMPTY);
                outs[outs.size() - 1].last = 1'b1;
            end
            default:
                outs.insert(outs.size(), RSP_EMPTY);
        endcase
        if (typed)
            awaited_rsp.insert(awaited_rsp.size(), want);
        else
            foreach (outs[k])
                awaited_rsp.insert(awaited_rsp.size(), outs[k]);
    endfunction

    task automatic note_mismatch(string what, teq_rsp_t want, teq_rsp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%s: exp v=%0b h=%h a=%h t=%0b s=%0b l=%0b",
                      " got v=%0b h=%h a=%h t=%0b s=%0b l=%0b"},
                     what, want.event_valid, want.fired_handle, want.fired_aux,
                     want.from_timed, want.status, want.last,
                     got.event_valid, got.fired_handle, got.fired_aux,
                     got.from_timed, got.status, got.last);
    endtask

    task automatic push_req(teq_req_t r, bit typed, teq_rsp_t want);
        int gap;
        gap = idle_gap(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= r;
        row_typed <= typed;
        row_want  <= want;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (r.cmd != CMD_UNUSED)
            stim_count++;
    endtask

    task automatic send(teq_req_t r);
        push_req(r, 1'b0, RSP_ACK);
    endtask

    // hold stall for a random stretch, then release it before the next stretch
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            rsp_stall  <= 1'b0;
            stall_left = idle_gap(rsp_calm);
        end
    end

    always @(posedge clk)
    begin : monitor
        teq_rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                predict_dispatch(req, row_typed, row_want);
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                    note_mismatch("unexpected transfer", RSP_EMPTY, rsp);
                else
                begin
                    want = awaited_rsp[0];
                    awaited_rsp.delete(0);
                    if (rsp !== want)
                        note_mismatch("result mismatch", want, rsp);
                end
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int               roll;
        int               n;
        logic [TIME_W-1:0] epoch_us;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        row_typed  = 1'b0;
        row_want   = RSP_ACK;
        stim_count = 0;
        send_calm  = 0;

        rows.insert(rows.size(), '{mk_req(CMD_POLL, 16'h0, 32'h0, 48'h0, 48'h0),
                                   1'b1, RSP_EMPTY});
        rows.insert(rows.size(), '{mk_req(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, TIME_MAX,
                                          TIME_MAX), 1'b1, RSP_EMPTY});
        rows.insert(rows.size(), '{mk_req(CMD_ADD_IMM, 16'h0, 32'h0, 48'h0, 48'h0),
                                   1'b1, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_ADD_IMM, 16'hFFFF, 32'hFFFF_FFFF, TIME_MAX,
                                          TIME_MAX), 1'b1, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_ADD_TIMED, 16'h0001, 32'hA5A5_A5A5, TIME_MAX,
                                          48'h0), 1'b1, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_ADD_TIMED, 16'h0010, 32'h1, 48'h0, 48'h0),
                                   1'b1, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_ADD_TIMED, 16'h0002, 32'h2, 48'd100, 48'h0),
                                   1'b1, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_ADD_TIMED, 16'h0003, 32'h3, 48'd100, 48'h0),
                                   1'b1, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_ADD_TIMED, 16'h0004, 32'h4, 48'd50, 48'h0),
                                   1'b1, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_POLL, 16'h0, 32'h0, 48'h0, 48'd99),
                                   1'b0, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_POLL, 16'h0, 32'h0, 48'h0, 48'd100),
                                   1'b0, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_POLL, 16'h0, 32'h0, 48'h0, 48'd100),
                                   1'b1, RSP_EMPTY});
        rows.insert(rows.size(), '{mk_req(CMD_POLL, 16'h0, 32'h0, 48'h0, TIME_MAX),
                                   1'b0, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_ADD_IMM, 16'h5A5A, 32'h1234_5678, 48'h0, 48'h0),
                                   1'b1, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_UNUSED, 16'h0, 32'h0, 48'h0, 48'h0),
                                   1'b1, RSP_EMPTY});
        rows.insert(rows.size(), '{mk_req(CMD_POLL, 16'h0, 32'h0, 48'h0, 48'h0),
                                   1'b0, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_ADD_TIMED, 16'h0005, 32'h5, 48'd1, 48'h0),
                                   1'b1, RSP_ACK});
        rows.insert(rows.size(), '{mk_req(CMD_POLL, 16'h0, 32'h0, 48'h0, 48'h0),
                                   1'b1, RSP_EMPTY});
        rows.insert(rows.size(), '{mk_req(CMD_POLL, 16'h0, 32'h0, 48'h0, 48'd1),
                                   1'b0, RSP_ACK});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[k])
            push_req(rows[k].req, rows[k].typed, rows[k].want);

        stim_count = 0;
        epoch_us   = 48'd1000;
        while (stim_count < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                epoch_us = ($urandom_range(0, 1) != 0) ? rand48()
                                                       : TIME_MAX - $urandom_range(0, 80);
            if (roll < 55)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    if ($urandom_range(0, 1) != 0)
                        send(mk_req(CMD_ADD_IMM, 16'($urandom), $urandom, rand48(), rand48()));
                    else
                        send(mk_req(CMD_ADD_TIMED, 16'($urandom), $urandom,
                                    ($urandom_range(0, 6) == 0) ? rand48()
                                        : epoch_us + $urandom_range(0, 30), rand48()));
                end
                send(mk_req(CMD_POLL, 16'($urandom), $urandom, rand48(),
                            epoch_us + $urandom_range(0, 40)));
            end
            else if (roll < 70)
            begin
                n = $urandom_range(IMM_DEPTH, IMM_DEPTH + 3);
                repeat (n)
                    send(mk_req(CMD_ADD_IMM, 16'($urandom), $urandom, rand48(), rand48()));
                send(mk_req(CMD_POLL, 16'($urandom), $urandom, rand48(),
                            epoch_us + $urandom_range(0, 20)));
            end
            else if (roll < 82)
            begin
                n = $urandom_range(TIMED_DEPTH - 2, TIMED_DEPTH + 3);
                repeat (n)
                    send(mk_req(CMD_ADD_TIMED, 16'($urandom), $urandom,
                                epoch_us + $urandom_range(0, 63), rand48()));
                send(mk_req(CMD_POLL, 16'($urandom), $urandom, rand48(),
                            epoch_us + $urandom_range(0, 63)));
                if ($urandom_range(0, 1) != 0)
                    send(mk_req(CMD_POLL, 16'($urandom), $urandom, rand48(), TIME_MAX));
            end
            else if (roll < 92)
            begin
                repeat ($urandom_range(1, 3))
                    send(mk_req(CMD_POLL, 16'($urandom), $urandom, rand48(), rand48()));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send(mk_req(2'($urandom_range(0, 3)), 16'($urandom), $urandom,
                                rand48(), rand48()));
            end
            epoch_us = epoch_us + $urandom_range(5, 40);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited_rsp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/teq_pkg.sv
rtl/core/teq_timed_store.sv
rtl/core/timed_event_queue.sv
tb/sv/tb_timed_event_queue.sv
